// ===== rtl/core/rate_pid_quad_motor_mixer_assert.svh =====
// Assertion macros for the rate controller checker.
`ifndef RATE_PID_QUAD_MOTOR_MIXER_ASSERT_SVH
`define RATE_PID_QUAD_MOTOR_MIXER_ASSERT_SVH

// Consequent checked in the same cycle.
`define RPQM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("rpqm check failed");

// Consequent checked in the following cycle.
`define RPQM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("rpqm check failed");

`endif

// ===== rtl/core/rpqm_pkg.sv =====
`default_nettype none
package rpqm_pkg;

    localparam int INTEG_WIDTH_DEF = 32;
    localparam int DIV_SHIFT       = 14;      // 256000000 = 2^14 * 15625
    localparam int DIV_ODD         = 15625;

    localparam logic [2:0] CFG_P_GAINS = 3'd0;
    localparam logic [2:0] CFG_I_GAINS = 3'd1;
    localparam logic [2:0] CFG_D_GAINS = 3'd2;
    localparam logic [2:0] CFG_BOUNDS  = 3'd3;
    localparam logic [2:0] CFG_MIXER   = 3'd4;

    // divider steps: 16-bit digits of the magnitude of Ki*v shifted down by DIV_SHIFT
    function automatic int div_iters(input int iw);
        return (iw + 16) / 16;
    endfunction

    // reciprocal of DIV_ODD scaled by 2^(iw+15), rounded up; exact over iw+1 bits
    function automatic logic [63:0] div_recip(input int iw);
        logic [127:0] num;
        num = (128'd1 << (iw + 15)) + 128'(DIV_ODD - 1);
        return 64'(num / 128'(DIV_ODD));
    endfunction

    // demand width
    function automatic int dem_width(input int iw);
        return ((iw > 36) ? (iw - 12) : 24) + 3;
    endfunction

    // root iterations over the squared-speed magnitude
    function automatic int root_iters(input int iw);
        return (dem_width(iw) + 11) / 2;
    endfunction

    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_INTEG = 10'b0000000010,
        S_MUL   = 10'b0000000100,
        S_DLD   = 10'b0000001000,
        S_DIV   = 10'b0000010000,
        S_DEM   = 10'b0000100000,
        S_MIX   = 10'b0001000000,
        S_SUM   = 10'b0010000000,
        S_SQRT  = 10'b0100000000,
        S_OUT   = 10'b1000000000
    } t_state;

    typedef struct packed {
        logic load;
        logic clear;
        logic integ;
        logic mul;
        logic div_load;
        logic div_step;
        logic demand;
        logic mix;
        logic sum;
        logic root_step;
        logic out_load;
    } t_dp_cmd;

endpackage
`default_nettype wire

// ===== rtl/core/rate_pid_quad_motor_mixer.sv =====
// Rate PID controller with X-quad mixer.
// Input channel: i_in_valid / o_in_ready carry one word: command, rate
// commands, measured rates and accelerations per axis, thrust and time step.
// Output channel: o_out_valid / i_out_ready carry the four motor speeds.
// Configuration: i_cfg_wr_en writes i_cfg_data to register i_cfg_index
// (0 P gains, 1 I gains, 2 D gains, 3 integrator bounds, 4 mixer gains).
// A clear word (command high) zeroes the integrators in its accept cycle and
// gives no output; the next word can be taken in the following cycle.
// An update word runs through a sequencer: integrate, multiply, scale the
// integral term by a reciprocal of the divisor one 16-bit digit a cycle,
// demand, mix, sum, then a two-bit-per-cycle square root on all four motors.
// A new word is taken only once the sequencer is back in idle, so updates do
// not overlap. The serial root is the longest step of the sequence.
// The finished word sits in an output register, so a stalled receiver holds
// only the last step; o_in_ready is high whenever the sequencer is idle.
// Reset is synchronous: gains go to zero, bounds to all ones, integrators to
// zero and both channels empty.
`default_nettype none
module rate_pid_quad_motor_mixer
    import rpqm_pkg::*;
#(
    parameter int INTEGRATOR_WIDTH = INTEG_WIDTH_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_wr_en,
    input  wire logic [2:0]         i_cfg_index,
    input  wire logic [63:0]        i_cfg_data,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic               i_command,
    input  wire logic signed [15:0] i_rate_cmd_roll,
    input  wire logic signed [15:0] i_rate_cmd_pitch,
    input  wire logic signed [15:0] i_rate_cmd_yaw,
    input  wire logic signed [15:0] i_meas_rate_roll,
    input  wire logic signed [15:0] i_meas_rate_pitch,
    input  wire logic signed [15:0] i_meas_rate_yaw,
    input  wire logic signed [15:0] i_meas_accel_roll,
    input  wire logic signed [15:0] i_meas_accel_pitch,
    input  wire logic signed [15:0] i_meas_accel_yaw,
    input  wire logic [15:0]        i_thrust_cmd,
    input  wire logic [15:0]        i_step_time,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic signed [15:0]      o_motor_speed_0,
    output logic signed [15:0]      o_motor_speed_1,
    output logic signed [15:0]      o_motor_speed_2,
    output logic signed [15:0]      o_motor_speed_3
);
    t_dp_cmd w_cmd;

    rpqm_ctrl #(
        .INTEG_WIDTH (INTEGRATOR_WIDTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_command   (i_command),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (w_cmd)
    );

    rpqm_dp #(
        .INTEG_WIDTH (INTEGRATOR_WIDTH)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_wr_en        (i_cfg_wr_en),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_cmd              (w_cmd),
        .i_rate_cmd_roll    (i_rate_cmd_roll),
        .i_rate_cmd_pitch   (i_rate_cmd_pitch),
        .i_rate_cmd_yaw     (i_rate_cmd_yaw),
        .i_meas_rate_roll   (i_meas_rate_roll),
        .i_meas_rate_pitch  (i_meas_rate_pitch),
        .i_meas_rate_yaw    (i_meas_rate_yaw),
        .i_meas_accel_roll  (i_meas_accel_roll),
        .i_meas_accel_pitch (i_meas_accel_pitch),
        .i_meas_accel_yaw   (i_meas_accel_yaw),
        .i_thrust_cmd       (i_thrust_cmd),
        .i_step_time        (i_step_time),
        .o_motor_speed_0    (o_motor_speed_0),
        .o_motor_speed_1    (o_motor_speed_1),
        .o_motor_speed_2    (o_motor_speed_2),
        .o_motor_speed_3    (o_motor_speed_3)
    );

endmodule
`default_nettype wire

// ===== rtl/core/rpqm_ctrl.sv =====
`default_nettype none
module rpqm_ctrl
    import rpqm_pkg::*;
#(
    parameter int INTEG_WIDTH = INTEG_WIDTH_DEF
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    input  wire logic    i_command,
    output logic         o_in_ready,
    output logic         o_out_valid,
    input  wire logic    i_out_ready,
    output t_dp_cmd      o_cmd
);
    localparam int NDIV  = div_iters(INTEG_WIDTH);
    localparam int NROOT = root_iters(INTEG_WIDTH);
    localparam int CW    = $clog2(((NDIV > NROOT) ? NDIV : NROOT) + 1);

    t_state          r_state, n_state;
    logic [CW-1:0]   r_cnt, n_cnt;
    logic            r_out_valid, n_out_valid;
    logic            w_accept, w_out_free;

    assign w_accept   = i_in_valid && (r_state == S_IDLE);
    assign w_out_free = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_command) begin
                        o_cmd.clear = 1'b1;
                    end else begin
                        o_cmd.load = 1'b1;
                        n_state    = S_INTEG;
                    end
                end
            end
            S_INTEG: begin
                o_cmd.integ = 1'b1;
                n_state     = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_DLD;
            end
            S_DLD: begin
                o_cmd.div_load = 1'b1;
                n_cnt          = '0;
                n_state        = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == CW'(NDIV - 1)) begin
                    n_state = S_DEM;
                end
            end
            S_DEM: begin
                o_cmd.demand = 1'b1;
                n_state      = S_MIX;
            end
            S_MIX: begin
                o_cmd.mix = 1'b1;
                n_state   = S_SUM;
            end
            S_SUM: begin
                o_cmd.sum = 1'b1;
                n_cnt     = '0;
                n_state   = S_SQRT;
            end
            S_SQRT: begin
                o_cmd.root_step = 1'b1;
                n_cnt           = r_cnt + 1'b1;
                if (r_cnt == CW'(NROOT - 1)) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                // hold until the output register is free
                if (w_out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/rpqm_dp.sv =====
`default_nettype none
module rpqm_dp
    import rpqm_pkg::*;
#(
    parameter int INTEG_WIDTH = INTEG_WIDTH_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_wr_en,
    input  wire logic [2:0]         i_cfg_index,
    input  wire logic [63:0]        i_cfg_data,
    input  wire t_dp_cmd            i_cmd,
    input  wire logic signed [15:0] i_rate_cmd_roll,
    input  wire logic signed [15:0] i_rate_cmd_pitch,
    input  wire logic signed [15:0] i_rate_cmd_yaw,
    input  wire logic signed [15:0] i_meas_rate_roll,
    input  wire logic signed [15:0] i_meas_rate_pitch,
    input  wire logic signed [15:0] i_meas_rate_yaw,
    input  wire logic signed [15:0] i_meas_accel_roll,
    input  wire logic signed [15:0] i_meas_accel_pitch,
    input  wire logic signed [15:0] i_meas_accel_yaw,
    input  wire logic [15:0]        i_thrust_cmd,
    input  wire logic [15:0]        i_step_time,
    output logic signed [15:0]      o_motor_speed_0,
    output logic signed [15:0]      o_motor_speed_1,
    output logic signed [15:0]      o_motor_speed_2,
    output logic signed [15:0]      o_motor_speed_3
);
    localparam int IW   = INTEG_WIDTH;
    localparam int VW   = ((IW > 34) ? IW : 34) + 1;
    localparam int NCH  = div_iters(IW);
    localparam int NB   = NCH * 16;
    localparam int MW   = IW + 2;
    localparam int AW   = NB + MW;
    localparam int QS   = IW + 15;
    localparam logic [MW-1:0] RECIP = MW'(div_recip(IW));
    localparam int DW   = dem_width(IW);
    localparam int PW   = DW + 19;
    localparam int SW   = DW + 10;
    localparam int RI   = root_iters(IW);
    localparam int IPW  = IW + 17;

    // configuration
    logic [47:0] r_pg, r_ig, r_dg, r_bnd;
    logic [63:0] r_mixg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pg   <= '0;
            r_ig   <= '0;
            r_dg   <= '0;
            r_bnd  <= '1;
            r_mixg <= '0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_P_GAINS: r_pg   <= i_cfg_data[47:0];
                CFG_I_GAINS: r_ig   <= i_cfg_data[47:0];
                CFG_D_GAINS: r_dg   <= i_cfg_data[47:0];
                CFG_BOUNDS:  r_bnd  <= i_cfg_data[47:0];
                CFG_MIXER:   r_mixg <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // per-axis and per-motor storage, step time and thrust
    logic signed [16:0]     r_e    [3];
    logic signed [15:0]     r_acc  [3];
    logic [15:0]            r_dt, r_thrust;
    logic signed [IW-1:0]   r_integ[3];
    logic signed [33:0]     r_pprod[3];
    logic signed [32:0]     r_dprod[3];
    logic signed [IPW-1:0]  r_iprod[3];
    logic [31:0]            r_thr;
    logic [NB-1:0]          r_num  [3];
    logic [AW-1:0]          r_mac  [3];
    logic                   r_ineg [3];
    logic signed [DW-1:0]   r_dem  [3];
    logic signed [DW+16:0]  r_prod [3];
    logic [2*RI-1:0]        r_sqm  [4];
    logic                   r_sqn  [4];
    logic [RI-1:0]          r_root [4];
    logic [RI+1:0]          r_srem [4];
    logic signed [15:0]     r_speed[4];

    logic signed [15:0] w_rc[3], w_mr[3], w_ma[3];
    assign w_rc = '{i_rate_cmd_roll, i_rate_cmd_pitch, i_rate_cmd_yaw};
    assign w_mr = '{i_meas_rate_roll, i_meas_rate_pitch, i_meas_rate_yaw};
    assign w_ma = '{i_meas_accel_roll, i_meas_accel_pitch, i_meas_accel_yaw};

    // integrator, multipliers, divider, demand, mix products: one lane per axis
    for (genvar a = 0; a < 3; a++) begin : g_axis
        logic signed [33:0]    w_edt;
        logic signed [VW-1:0]  w_v, w_b, w_vc;
        logic signed [IPW-1:0] w_ip;
        logic [IPW-1:0]        w_imag;
        logic [MW+15:0]        w_pp;
        logic signed [33:0]    w_pt;
        logic signed [32:0]    w_dt;
        logic signed [DW-1:0]  w_q;

        assign w_edt = 34'(r_e[a]) * $signed({18'd0, r_dt});
        assign w_v   = VW'(r_integ[a]) + VW'(w_edt);
        assign w_b   = $signed({{(VW-IW+1){1'b0}}, r_bnd[16*a +: 16], {(IW-17){1'b0}}});
        always_comb begin
            w_vc = w_v;
            if (w_vc > w_b) w_vc = w_b;
            if (w_vc < -w_b) w_vc = -w_b;
        end

        assign w_ip   = r_iprod[a];
        assign w_imag = w_ip[IPW-1] ? IPW'(-w_ip) : IPW'(w_ip);
        assign w_pp   = (MW+16)'(r_num[a][NB-1 -: 16]) * (MW+16)'(RECIP);

        // truncate toward zero on the divide by 256
        assign w_pt = (r_pprod[a] + (r_pprod[a][33] ? 34'sd255 : 34'sd0)) >>> 8;
        assign w_dt = (r_dprod[a] + (r_dprod[a][32] ? 33'sd255 : 33'sd0)) >>> 8;
        assign w_q  = r_ineg[a] ? -$signed(DW'(r_mac[a][AW-1:QS]))
                                : $signed(DW'(r_mac[a][AW-1:QS]));

        always_ff @(posedge i_clk) begin
            if (i_cmd.load) begin
                r_e[a]   <= 17'(w_rc[a]) - 17'(w_mr[a]);
                r_acc[a] <= w_ma[a];
            end
            if (i_cmd.mul) begin
                r_pprod[a] <= $signed({18'd0, r_pg[16*a +: 16]}) * 34'(r_e[a]);
                r_dprod[a] <= $signed({17'd0, r_dg[16*a +: 16]}) * 33'(r_acc[a]);
                r_iprod[a] <= $signed({{(IPW-16){1'b0}}, r_ig[16*a +: 16]})
                              * IPW'(r_integ[a]);
            end
            if (i_cmd.div_load) begin
                r_num[a]  <= NB'(w_imag[IW+14:DIV_SHIFT]);
                r_mac[a]  <= '0;
                r_ineg[a] <= w_ip[IPW-1];
            end else if (i_cmd.div_step) begin
                // advance one 16-bit digit of the numerator, high digit first
                r_num[a] <= {r_num[a][NB-17:0], 16'd0};
                r_mac[a] <= {r_mac[a][AW-17:0], 16'd0} + AW'(w_pp);
            end
            if (i_cmd.demand) begin
                r_dem[a] <= DW'(w_pt) + w_q - DW'(w_dt);
            end
            if (i_cmd.mix) begin
                r_prod[a] <= $signed({{DW{1'b0}}, r_mixg[16*a +: 16]})
                             * (DW+17)'(r_dem[a]);
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n || i_cmd.clear) begin
                r_integ[a] <= '0;
            end else if (i_cmd.integ) begin
                r_integ[a] <= IW'(w_vc);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_dt     <= i_step_time;
            r_thrust <= i_thrust_cmd;
        end
        if (i_cmd.mul) begin
            r_thr <= 32'(r_mixg[63:48]) * 32'(r_thrust);
        end
    end

    // mixer: signed sums per motor
    logic signed [PW-1:0] w_p[3];
    logic signed [PW-1:0] w_t[4];
    assign w_p[0] = PW'(r_prod[0]);
    assign w_p[1] = PW'(r_prod[1]);
    assign w_p[2] = PW'(r_prod[2]);
    assign w_t[0] =  w_p[0] - w_p[1] - w_p[2];
    assign w_t[1] =  w_p[0] + w_p[1] + w_p[2];
    assign w_t[2] = -w_p[0] + w_p[1] - w_p[2];
    assign w_t[3] = -w_p[0] - w_p[1] + w_p[2];

    for (genvar m = 0; m < 4; m++) begin : g_motor
        logic signed [PW-1:0] w_tq;
        logic signed [SW-1:0] w_s;
        logic [SW-1:0]        w_mag;
        logic [RI+1:0]        w_rsh, w_trial;
        logic                 w_ge;
        logic signed [15:0]   w_sat;

        assign w_tq  = (w_t[m] + (w_t[m][PW-1] ? PW'(1023) : PW'(0))) >>> 10;
        assign w_s   = SW'(w_tq) + $signed({{(SW-32){1'b0}}, r_thr});
        assign w_mag = w_s[SW-1] ? SW'(-w_s) : SW'(w_s);

        assign w_rsh   = {r_srem[m][RI-1:0], r_sqm[m][2*RI-1 -: 2]};
        assign w_trial = {r_root[m], 2'b01};
        assign w_ge    = (w_rsh >= w_trial);

        always_comb begin
            if (r_sqn[m]) begin
                w_sat = (r_root[m] > RI'(32768)) ? -16'sd32768 : -$signed(r_root[m][15:0]);
            end else begin
                w_sat = (r_root[m] > RI'(32767)) ? 16'sd32767 : $signed(r_root[m][15:0]);
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_cmd.sum) begin
                r_sqm[m]  <= (2*RI)'(w_mag);
                r_sqn[m]  <= w_s[SW-1];
                r_root[m] <= '0;
                r_srem[m] <= '0;
            end else if (i_cmd.root_step) begin
                r_sqm[m]  <= {r_sqm[m][2*RI-3:0], 2'b00};
                r_srem[m] <= w_ge ? (w_rsh - w_trial) : w_rsh;
                r_root[m] <= {r_root[m][RI-2:0], w_ge};
            end
            if (i_cmd.out_load) begin
                r_speed[m] <= w_sat;
            end
        end
    end

    assign o_motor_speed_0 = r_speed[0];
    assign o_motor_speed_1 = r_speed[1];
    assign o_motor_speed_2 = r_speed[2];
    assign o_motor_speed_3 = r_speed[3];

endmodule
`default_nettype wire

// ===== rtl/core/rpqm_checker.sv =====
`default_nettype none
`include "rate_pid_quad_motor_mixer_assert.svh"
module rpqm_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        o_in_ready,
    input wire logic        i_command,
    input wire logic        o_out_valid,
    input wire logic        i_out_ready,
    input wire logic [15:0] o_motor_speed_0
);
    // a result waits until taken
    `RPQM_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid)
    // a stalled result keeps its motor 0 speed
    `RPQM_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, o_out_valid && !i_out_ready,
        $stable(o_motor_speed_0))
    // an update word occupies the sequencer
    `RPQM_ASSERT_NEXT(a_busy, i_clk, i_rst_n, i_in_valid && o_in_ready && !i_command,
        !o_in_ready)
    // a clear word leaves the block ready and adds no result
    `RPQM_ASSERT_NEXT(a_clear, i_clk, i_rst_n, i_in_valid && o_in_ready && i_command,
        o_in_ready && !$rose(o_out_valid))
endmodule

bind rate_pid_quad_motor_mixer rpqm_checker u_rpqm_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in_valid),
    .o_in_ready      (o_in_ready),
    .i_command       (i_command),
    .o_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .o_motor_speed_0 (o_motor_speed_0)
);
`default_nettype wire

// ===== tb/rate_pid_quad_motor_mixer_tb.sv =====
`timescale 1ns / 1ps
`default_nettype none
module rate_pid_quad_motor_mixer_tb;
    import rpqm_pkg::*;

    localparam int IW = 32;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam logic CMD_UPDATE = 1'b0;
    localparam logic CMD_CLEAR  = 1'b1;

    typedef struct packed {
        logic               command;
        logic signed [15:0] cmd_r, cmd_p, cmd_y;
        logic signed [15:0] rate_r, rate_p, rate_y;
        logic signed [15:0] acc_r, acc_p, acc_y;
        logic [15:0]        thrust;
        logic [15:0]        dt;
    } t_word;

    localparam int WORD_W = $bits(t_word);

    typedef struct packed {
        logic signed [15:0] m0, m1, m2, m3;
    } t_speeds;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_wr_en = 1'b0;
    logic [2:0]  i_cfg_index = '0;
    logic [63:0] i_cfg_data = '0;
    logic        i_in_valid = 1'b0;
    logic        i_out_ready = 1'b0;
    t_word       drv = '0;
    logic        o_in_ready, o_out_valid;
    logic signed [15:0] o_motor_speed_0, o_motor_speed_1, o_motor_speed_2, o_motor_speed_3;

    rate_pid_quad_motor_mixer u_top (
        .i_clk, .i_rst_n, .i_cfg_wr_en, .i_cfg_index, .i_cfg_data,
        .i_in_valid, .o_in_ready,
        .i_command(drv.command),
        .i_rate_cmd_roll(drv.cmd_r), .i_rate_cmd_pitch(drv.cmd_p),
        .i_rate_cmd_yaw(drv.cmd_y),
        .i_meas_rate_roll(drv.rate_r), .i_meas_rate_pitch(drv.rate_p),
        .i_meas_rate_yaw(drv.rate_y),
        .i_meas_accel_roll(drv.acc_r), .i_meas_accel_pitch(drv.acc_p),
        .i_meas_accel_yaw(drv.acc_y),
        .i_thrust_cmd(drv.thrust), .i_step_time(drv.dt),
        .o_out_valid, .i_out_ready,
        .o_motor_speed_0, .o_motor_speed_1, .o_motor_speed_2, .o_motor_speed_3
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // predictor state
    logic [47:0] kp, ki, kd, bounds;
    logic [63:0] mix;
    longint      integ [3];
    t_speeds     speed_queue [$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_off = 0;
    int mismatches = 0;
    int results_seen = 0;
    int updates_sent = 0;
    int clears_sent = 0;
    int quiet_cycles = 0;

    function automatic longint root_of(longint s);
        longint mag, r, b;
        mag = (s < 0) ? -s : s;
        r = 0;
        b = 64'sd1 <<< 62;
        while (b > mag) b = b >>> 2;
        while (b != 0) begin
            if (mag >= r + b) begin
                mag = mag - (r + b);
                r = (r >>> 1) + b;
            end else begin
                r = r >>> 1;
            end
            b = b >>> 2;
        end
        if (s < 0) return (r > 32768) ? -32768 : -r;
        return (r > 32767) ? 32767 : r;
    endfunction

    function automatic longint lane(logic [63:0] v, int k);
        return longint'({48'd0, v[16*k +: 16]});
    endfunction

    task automatic predict_speeds(t_word w);
        longint e, acc, bnd, v, dem, prod [3], thr, sq [4];
        logic signed [15:0] cmds [3], rates [3], accs [3];
        t_speeds s;
        if (w.command == CMD_CLEAR) begin
            integ[0] = 0; integ[1] = 0; integ[2] = 0;
            return;
        end
        cmds = '{w.cmd_r, w.cmd_p, w.cmd_y};
        rates = '{w.rate_r, w.rate_p, w.rate_y};
        accs = '{w.acc_r, w.acc_p, w.acc_y};
        for (int a = 0; a < 3; a++) begin
            e = longint'(cmds[a]) - longint'(rates[a]);
            acc = longint'(accs[a]);
            bnd = lane({16'd0, bounds}, a) <<< (IW - 17);
            v = integ[a] + e * longint'({48'd0, w.dt});
            if (v > bnd) v = bnd;
            if (v < -bnd) v = -bnd;
            integ[a] = v;
            dem = (lane({16'd0, kp}, a) * e) / 256 + (lane({16'd0, ki}, a) * v) / 256000000
                - (lane({16'd0, kd}, a) * acc) / 256;
            prod[a] = lane(mix, a) * dem;
        end
        thr = lane(mix, 3) * longint'({48'd0, w.thrust});
        sq[0] = ( prod[0] - prod[1] - prod[2]) / 1024 + thr;
        sq[1] = ( prod[0] + prod[1] + prod[2]) / 1024 + thr;
        sq[2] = (-prod[0] + prod[1] - prod[2]) / 1024 + thr;
        sq[3] = (-prod[0] - prod[1] + prod[2]) / 1024 + thr;
        s.m0 = 16'(root_of(sq[0]));
        s.m1 = 16'(root_of(sq[1]));
        s.m2 = 16'(root_of(sq[2]));
        s.m3 = 16'(root_of(sq[3]));
        speed_queue.push_back(s);
    endtask

    task automatic send_word(t_word w);
        while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        drv <= w;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        predict_speeds(w);
        if (w.command == CMD_CLEAR) clears_sent++; else updates_sent++;
    endtask

    task automatic write_reg(logic [2:0] idx, logic [63:0] val);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        case (idx)
            CFG_P_GAINS: kp = val[47:0];
            CFG_I_GAINS: ki = val[47:0];
            CFG_D_GAINS: kd = val[47:0];
            CFG_BOUNDS:  bounds = val[47:0];
            CFG_MIXER:   mix = val;
            default: ;
        endcase
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (speed_queue.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    function automatic t_word random_word(bit allow_clear);
        t_word w;
        w = t_word'(WORD_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom}));
        w.command = (allow_clear && $urandom_range(19, 0) == 0) ? CMD_CLEAR : CMD_UPDATE;
        // mostly modest roll errors and time steps so the roll integrator stays below its bound more often
        if ($urandom_range(3, 0) != 0) begin
            w.cmd_r = $signed(16'($urandom_range(4000, 0))) - 16'sd2000;
            w.rate_r = $signed(16'($urandom_range(4000, 0))) - 16'sd2000;
            w.dt = 16'($urandom_range(2000, 0));
        end
        return w;
    endfunction

    function automatic logic [63:0] random_gains();
        return {$urandom, $urandom};
    endfunction

    task automatic test_directed();
        t_word w;
        write_reg(CFG_P_GAINS, 64'h0100_0200_0100);
        write_reg(CFG_I_GAINS, 64'hFFFF_FFFF_FFFF);
        write_reg(CFG_D_GAINS, 64'h0080_0040_0020);
        write_reg(CFG_MIXER, 64'h0010_0100_0100_0100);
        // extremes of every field
        w = '0;
        send_word(w);
        w = '{CMD_UPDATE, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, -16'sh8000, -16'sh8000, -16'sh8000,
              -16'sh8000, -16'sh8000, -16'sh8000, 16'hFFFF, 16'hFFFF};
        send_word(w);
        send_word(w);
        w = '{CMD_UPDATE, -16'sh8000, -16'sh8000, -16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF,
              16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'h0000, 16'hFFFF};
        send_word(w);
        // zero time step re-clamps only
        w.dt = 16'h0;
        send_word(w);
        w.command = CMD_CLEAR;
        send_word(w);
        w.command = CMD_UPDATE;
        w.dt = 16'd5000;
        send_word(w);
        drain();
        // bound lowered, then zero bound
        write_reg(CFG_BOUNDS, 64'h0000_0001_0010_0100);
        send_word(w);
        w.dt = 16'd0;
        send_word(w);
        drain();
        write_reg(CFG_BOUNDS, 64'h0);
        send_word(w);
        w.dt = 16'hFFFF;
        send_word(w);
        drain();
        // saturating squared speeds in both directions
        write_reg(CFG_MIXER, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(CFG_P_GAINS, 64'hFFFF_FFFF_FFFF);
        w.thrust = 16'hFFFF;
        send_word(w);
        w.thrust = 16'h0;
        send_word(w);
        w.cmd_r = 16'sh7FFF;
        w.rate_r = -16'sh8000;
        send_word(w);
        drain();
        // out-of-range indexes are ignored
        write_reg(3'd5, 64'h0);
        write_reg(3'd7, 64'h0);
        write_reg(CFG_BOUNDS, 64'hFFFF_FFFF_FFFF);
        send_word(w);
        drain();
    endtask

    task automatic test_random(int count, int sidle, int ridle);
        send_idle_pct = sidle;
        recv_idle_pct = ridle;
        write_reg(CFG_P_GAINS, random_gains());
        write_reg(CFG_I_GAINS, random_gains());
        write_reg(CFG_D_GAINS, $urandom_range(1, 0) ? random_gains() : 64'h0);
        write_reg(CFG_BOUNDS, $urandom_range(1, 0) ? random_gains() : 64'h0000_00FF_0FFF_FFFF);
        write_reg(CFG_MIXER, random_gains());
        for (int n = 0; n < count; n++) send_word(random_word(1'b1));
        drain();
    endtask

    task automatic test_backpressure();
        t_word w;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_off = 400;
        for (int n = 0; n < 6; n++) begin
            w = random_word(1'b0);
            send_word(w);
        end
        drain();
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= !(recv_idle_pct > 0 && $urandom_range(99, 0) < recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_speeds got, want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got = '{o_motor_speed_0, o_motor_speed_1, o_motor_speed_2, o_motor_speed_3};
            results_seen++;
            if (speed_queue.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected word %h", got);
            end else begin
                want = speed_queue.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("motor speeds: expected %0d %0d %0d %0d got %0d %0d %0d %0d",
                                 want.m0, want.m1, want.m2, want.m3,
                                 got.m0, got.m1, got.m2, got.m3);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || i_cfg_wr_en
            || hold_off > 0 || !i_rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[rate_pid_quad_motor_mixer] ERROR");
            $finish;
        end
    end

    initial begin
        kp = '0; ki = '0; kd = '0; bounds = '1; mix = '0;
        integ[0] = 0; integ[1] = 0; integ[2] = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(530, 34, 49);
        test_random(530, 49, 34);
        test_backpressure();
        test_random(530, 0, 0);
        if (speed_queue.size() != 0) mismatches += speed_queue.size();
        $display("covered %0d updates and %0d clears, %0d results checked",
                 updates_sent, clears_sent, results_seen);
        $display("gain, bound and mixer settings varied with idle, stall and hold-off phases");
        if (mismatches == 0)
            $display("[rate_pid_quad_motor_mixer] OK");
        else
            $display("[rate_pid_quad_motor_mixer] ERROR");
        $finish;
    end
endmodule
`default_nettype wire
